// ----- rtl/ppiu_pkg.sv -----
`default_nettype none

package ppiu_pkg;

	// Configuration port geometry and register map.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_X_ORIGIN    = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN    = 3'd1;
	localparam logic [2:0] REG_COLOR_ONE   = 3'd2;
	localparam logic [2:0] REG_COLOR_TWO   = 3'd3;
	localparam logic [2:0] REG_COLOR_THREE = 3'd4;

	// Palette reset colors (RGB565).
	localparam logic [15:0] COLOR_ONE_RST   = 16'h23D4;
	localparam logic [15:0] COLOR_TWO_RST   = 16'hFFE0;
	localparam logic [15:0] COLOR_THREE_RST = 16'h001F;

	localparam logic [7:0] PALETTE_ENTRIES = 8'd3;

	// Slots in one data byte: at one bit per pixel a byte holds eight pixels.
	localparam int SLOTS = 8;

	// Job queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [15:0] one;
		logic [15:0] two;
		logic [15:0] three;
	} palette_t;

	// One byte's worth of work for the back end.
	typedef struct packed {
		logic              derr;
		logic [7:0]        data;
		logic [3:0]        depth;
		logic [15:0]       base_x;
		logic [15:0]       base_y;
		logic [SLOTS-1:0]  mask;
	} job_t;

	// Pixels held in one byte for a valid depth, zero otherwise.
	function automatic logic [3:0] pixels_per_byte(input logic [3:0] depth);
		logic [3:0] n;
		case (depth)
			4'd1: n = 4'd8;
			4'd2: n = 4'd4;
			4'd4: n = 4'd2;
			4'd8: n = 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Palette index held in slot k of a byte, most significant slot first.
	function automatic logic [7:0] slot_index(input logic [7:0] data, input logic [3:0] depth,
			input logic [2:0] k);
		logic [2:0] s;
		logic [7:0] sh;
		logic [7:0] idx;
		s = 3'd0;
		case (depth)
			4'd1: s = ~k;
			4'd2: s = 3'd6 - {k[1:0], 1'b0};
			4'd4: s = k[0] ? 3'd0 : 3'd4;
			default: s = 3'd0;
		endcase
		sh = data >> s;
		case (depth)
			4'd1: idx = sh & 8'h01;
			4'd2: idx = sh & 8'h03;
			4'd4: idx = sh & 8'h0F;
			4'd8: idx = data;
			default: idx = 8'd0;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ppiu_byte_if.sv -----
`default_nettype none

interface ppiu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       icon_start;

	modport source (output valid, output data_byte, output icon_start, input ready);
	modport sink (input valid, input data_byte, input icon_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/ppiu_pixel_if.sv -----
`default_nettype none

interface ppiu_pixel_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [15:0] pixel_color;
	logic        index_out_of_palette;
	logic        depth_error;
	logic        last_of_byte;

	modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
		output index_out_of_palette, output depth_error, output last_of_byte, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input pixel_color,
		input index_out_of_palette, input depth_error, input last_of_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/packed_palette_icon_unpacker.sv -----
`default_nettype none

// Channel   Dir  Handshake      Payload
// icon      in   valid/ready    data_byte[7:0], icon_start
// pixel     out  valid/ready    pixel_x, pixel_y, pixel_color, index_out_of_palette,
//                               depth_error, last_of_byte
// apb       in   psel/penable   paddr[4:0], pwdata[31:0], prdata[31:0], pready
//
// The front end takes one byte per cycle while the four-entry job queue has room.
// The back end sends one pixel per cycle while pixel.ready holds; bytes without
// results never reach the back end.
// A byte's results pass the job queue, current job register and result register.
// Reset clears the parser, queue and result register and loads the default palette.
// A stalled pixel channel fills the queue, and then icon.ready drops.

module packed_palette_icon_unpacker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ppiu_pkg::ADDR_W-1:0] paddr,
	input  wire logic [ppiu_pkg::DATA_W-1:0] pwdata,
	output logic      [ppiu_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	ppiu_byte_if.sink                        icon,
	ppiu_pixel_if.source                     pixel
);
	import ppiu_pkg::*;

	logic [15:0] x_origin_q;
	logic [15:0] y_origin_q;
	palette_t    palette_q;
	logic        wr_en;
	logic [2:0]  reg_sel;

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	job_t        push_job;
	job_t        head_job;

	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q      <= 16'd0;
			y_origin_q      <= 16'd0;
			palette_q.one   <= COLOR_ONE_RST;
			palette_q.two   <= COLOR_TWO_RST;
			palette_q.three <= COLOR_THREE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_X_ORIGIN:    x_origin_q      <= pwdata[15:0];
				REG_Y_ORIGIN:    y_origin_q      <= pwdata[15:0];
				REG_COLOR_ONE:   palette_q.one   <= pwdata[15:0];
				REG_COLOR_TWO:   palette_q.two   <= pwdata[15:0];
				REG_COLOR_THREE: palette_q.three <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_sel)
			REG_X_ORIGIN:    prdata = DATA_W'(x_origin_q);
			REG_Y_ORIGIN:    prdata = DATA_W'(y_origin_q);
			REG_COLOR_ONE:   prdata = DATA_W'(palette_q.one);
			REG_COLOR_TWO:   prdata = DATA_W'(palette_q.two);
			REG_COLOR_THREE: prdata = DATA_W'(palette_q.three);
			default:         prdata = '0;
		endcase
	end

	ppiu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.icon     (icon),
		.x_origin (x_origin_q),
		.y_origin (y_origin_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	ppiu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	ppiu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.palette  (palette_q),
		.head_job (head_job),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.pixel    (pixel)
	);

	// The front end never writes a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("job pushed into full queue");

	// The back end never takes from an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty)) else $error("job popped from empty queue");

	// A depth error result carries no position, color or palette flag and ends its byte.
	a_derr_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.depth_error) |->
		(pixel.pixel_x == 16'd0 && pixel.pixel_y == 16'd0 && pixel.pixel_color == 16'd0 &&
		!pixel.index_out_of_palette && pixel.last_of_byte))
		else $error("depth error result carries pixel data");

	// An out-of-palette pixel is drawn with color zero.
	a_oop_black: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.index_out_of_palette) |-> (pixel.pixel_color == 16'd0))
		else $error("out-of-palette pixel has a color");

endmodule

`default_nettype wire

// ----- rtl/ppiu_front.sv -----
`default_nettype none

module ppiu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	ppiu_byte_if.sink          icon,
	input  wire logic [15:0]   x_origin,
	input  wire logic [15:0]   y_origin,
	input  wire logic          q_full,
	output logic               q_push,
	output ppiu_pkg::job_t     q_job
);
	import ppiu_pkg::*;

	typedef enum logic [2:0] {
		HP_IDLE      = 3'd0,
		HP_DEPTH     = 3'd1,
		HP_WIDTH_HI  = 3'd2,
		HP_WIDTH_LO  = 3'd3,
		HP_HEIGHT_HI = 3'd4,
		HP_HEIGHT_LO = 3'd5,
		HP_PIXELS    = 3'd6,
		HP_DONE      = 3'd7
	} hdr_state_t;

	hdr_state_t       hp_q;
	logic [3:0]       bpp_q;
	logic [15:0]      width_q;
	logic [15:0]      height_q;
	logic [15:0]      col_q;
	logic [15:0]      row_q;

	logic             accept;
	logic [7:0]       b;
	logic [3:0]       ppb;
	logic [15:0]      rem;
	logic [16:0]      col_sum;
	logic             row_end;
	logic [15:0]      row_next;
	logic [15:0]      height_new;
	logic [SLOTS-1:0] mask;

	assign icon.ready = !q_full;
	assign accept     = icon.valid && icon.ready;
	assign b          = icon.data_byte;

	// Classify the pixels of a data byte: which slots lie in the row and are opaque.
	always_comb begin
		ppb        = pixels_per_byte(bpp_q);
		rem        = width_q - col_q;
		col_sum    = {1'b0, col_q} + 17'(ppb);
		row_end    = col_sum >= {1'b0, width_q};
		row_next   = row_q + 16'd1;
		height_new = {height_q[15:8], b};
		for (int k = 0; k < SLOTS; k++) begin
			mask[k] = (4'(k) < ppb) && (16'(k) < rem) &&
				(slot_index(b, bpp_q, 3'(k)) != 8'd0);
		end
	end

	// Build the job and decide whether it goes to the back end.
	always_comb begin
		q_job.derr   = (hp_q == HP_HEIGHT_LO);
		q_job.data   = b;
		q_job.depth  = bpp_q;
		q_job.base_x = x_origin + col_q;
		q_job.base_y = y_origin + row_q;
		q_job.mask   = (hp_q == HP_HEIGHT_LO) ? SLOTS'(1) : mask;
		q_push = accept && !icon.icon_start &&
			(((hp_q == HP_HEIGHT_LO) && (bpp_q == 4'd0)) ||
			((hp_q == HP_PIXELS) && (mask != '0)));
	end

	// Header parser and row/column tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q     <= HP_IDLE;
			bpp_q    <= 4'd0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			col_q    <= 16'd0;
			row_q    <= 16'd0;
		end else if (accept) begin
			if (icon.icon_start) begin
				hp_q     <= HP_DEPTH;
				bpp_q    <= 4'd0;
				width_q  <= 16'd0;
				height_q <= 16'd0;
				col_q    <= 16'd0;
				row_q    <= 16'd0;
			end else begin
				case (hp_q)
					HP_DEPTH: begin
						bpp_q <= (b inside {8'd1, 8'd2, 8'd4, 8'd8}) ? b[3:0] : 4'd0;
						hp_q  <= HP_WIDTH_HI;
					end
					HP_WIDTH_HI: begin
						width_q[15:8] <= b;
						hp_q          <= HP_WIDTH_LO;
					end
					HP_WIDTH_LO: begin
						width_q[7:0] <= b;
						hp_q         <= HP_HEIGHT_HI;
					end
					HP_HEIGHT_HI: begin
						height_q[15:8] <= b;
						hp_q           <= HP_HEIGHT_LO;
					end
					HP_HEIGHT_LO: begin
						height_q <= height_new;
						col_q    <= 16'd0;
						row_q    <= 16'd0;
						if (bpp_q == 4'd0 || width_q == 16'd0 || height_new == 16'd0) begin
							hp_q <= HP_DONE;
						end else begin
							hp_q <= HP_PIXELS;
						end
					end
					HP_PIXELS: begin
						if (ppb == 4'd0) begin
							hp_q <= HP_DONE;
						end else if (row_end) begin
							col_q <= 16'd0;
							row_q <= row_next;
							if (row_next >= height_q) begin
								hp_q <= HP_DONE;
							end
						end else begin
							col_q <= col_sum[15:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ppiu_queue.sv -----
`default_nettype none

module ppiu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ppiu_pkg::job_t  push_job,
	input  wire logic            pop,
	output ppiu_pkg::job_t       head_job,
	output logic                 full,
	output logic                 empty
);
	import ppiu_pkg::*;

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full     = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign head_job = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ppiu_back.sv -----
`default_nettype none

module ppiu_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ppiu_pkg::palette_t palette,
	input  wire ppiu_pkg::job_t    head_job,
	input  wire logic              q_empty,
	output logic                   q_pop,
	ppiu_pixel_if.source           pixel
);
	import ppiu_pkg::*;

	logic             cur_valid_q;
	job_t             cur_q;
	logic [SLOTS-1:0] cur_mask_q;

	logic             out_valid_q;
	logic [15:0]      out_x_q;
	logic [15:0]      out_y_q;
	logic [15:0]      out_color_q;
	logic             out_oop_q;
	logic             out_derr_q;
	logic             out_last_q;

	logic             out_load;
	logic             issue;
	logic             finishing;
	logic [2:0]       k_sel;
	logic [SLOTS-1:0] rest;
	logic [7:0]       idx;
	logic [15:0]      color;
	logic             oop;

	// Pick the next opaque slot, lowest first, and look up its color.
	always_comb begin
		k_sel = 3'd0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (cur_mask_q[k]) begin
				k_sel = 3'(k);
			end
		end
		rest = cur_mask_q & (cur_mask_q - 1'b1);
		idx  = slot_index(cur_q.data, cur_q.depth, k_sel);
		oop  = idx > PALETTE_ENTRIES;
		case (idx)
			8'd1: color = palette.one;
			8'd2: color = palette.two;
			8'd3: color = palette.three;
			default: color = 16'd0;
		endcase
		if (oop) begin
			color = 16'd0;
		end
	end

	assign out_load  = !out_valid_q || pixel.ready;
	assign issue     = cur_valid_q && out_load;
	assign finishing = issue && (rest == '0);
	assign q_pop     = !q_empty && (!cur_valid_q || finishing);

	// Current job and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (finishing) begin
				cur_valid_q <= 1'b0;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Job payload and result fields.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q      <= head_job;
			cur_mask_q <= head_job.mask;
		end else if (issue) begin
			cur_mask_q <= rest;
		end
		if (issue) begin
			out_last_q <= rest == '0;
			out_derr_q <= cur_q.derr;
			if (cur_q.derr) begin
				out_x_q     <= 16'd0;
				out_y_q     <= 16'd0;
				out_color_q <= 16'd0;
				out_oop_q   <= 1'b0;
			end else begin
				out_x_q     <= cur_q.base_x + 16'(k_sel);
				out_y_q     <= cur_q.base_y;
				out_color_q <= color;
				out_oop_q   <= oop;
			end
		end
	end

	assign pixel.valid                = out_valid_q;
	assign pixel.pixel_x              = out_x_q;
	assign pixel.pixel_y              = out_y_q;
	assign pixel.pixel_color          = out_color_q;
	assign pixel.index_out_of_palette = out_oop_q;
	assign pixel.depth_error          = out_derr_q;
	assign pixel.last_of_byte         = out_last_q;

endmodule

`default_nettype wire
